// File: sv/sesup_pkg.sv
// Shared types and constants for the self-test error supervisor.
package sesup_pkg;

  // Field widths fixed by the item format
  localparam int unsigned SlotW    = 4;
  localparam int unsigned CountW   = 4;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LimitsW  = 36;
  localparam int unsigned CfgIdxW  = 2;

  // Slots that own a limit nibble; slots beyond these read a zero limit
  localparam int unsigned LimitSlots = LimitsW / CountW;

  // Register reset values
  localparam logic [LimitsW-1:0] LimitsReset  = 36'h1_1113_1111;
  localparam logic [TimeW-1:0]   TimeoutReset = 32'd10000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LIMITS  = 2'd0,
    REG_TIMEOUT = 2'd1
  } reg_idx_e;

  // Item kind
  typedef enum logic {
    ACT_REPORT = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  // Test status codes
  typedef enum logic [1:0] {
    ST_NOT_STARTED = 2'd0,
    ST_PASS        = 2'd1,
    ST_IN_PROGRESS = 2'd2,
    ST_FAIL        = 2'd3
  } status_e;

  // Input beat held in the input register
  typedef struct packed {
    action_e          action;
    status_e          test_status;
    logic             test_enabled;
    logic [TimeW-1:0] now_ms;
    logic [SlotW-1:0] read_index;
  } in_beat_t;

  // Result beat held in the output register
  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic              run_enabled;
    logic [CountW-1:0] error_count;
    logic [TotalW-1:0] total_errors;
    logic              count_cleared;
    logic              warning;
    logic              failed_now;
    logic              heartbeat;
    logic [SlotW-1:0]  next_slot;
    logic              all_pass;
  } out_beat_t;

endpackage

// File: sv/selftest_error_supervisor.sv
// Self-test error supervisor: per-slot error counting, timeout clear and blocking.
//
// Supervises a round-robin of NUM_SLOTS safety self-test slots. A report beat
// handles the current slot: an error count below its limit is cleared once
// the last error is at least timeout_q old, a fail is counted and
// time-stamped, and a slot at its limit is blocked and flags a heartbeat.
// A read beat returns the counters of read_index. The block takes one beat
// per clock cycle unless the result channel stalls. A beat lands in the
// input register at the edge that takes it. Its result is loaded into the
// result register at the next free edge. The per-slot counters and time
// stamps live in flip-flops and are read, updated and written back between
// those two registers, at the edge that loads the result. Write the
// configuration registers only while no beat is in flight.
module selftest_error_supervisor #(
  parameter int unsigned NUM_SLOTS = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [sesup_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sesup_pkg::LimitsW-1:0]      cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [1:0]                         test_status_i,
  input  logic                               test_enabled_i,
  input  logic [sesup_pkg::TimeW-1:0]        now_ms_i,
  input  logic [sesup_pkg::SlotW-1:0]        read_index_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sesup_pkg::SlotW-1:0]        slot_o,
  output logic                               run_enabled_o,
  output logic [sesup_pkg::CountW-1:0]       error_count_o,
  output logic [sesup_pkg::TotalW-1:0]       total_errors_o,
  output logic                               count_cleared_o,
  output logic                               warning_o,
  output logic                               failed_now_o,
  output logic                               heartbeat_o,
  output logic [sesup_pkg::SlotW-1:0]        next_slot_o,
  output logic                               all_pass_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [sesup_pkg::SlotW-1:0] LastSlot = sesup_pkg::SlotW'(NUM_SLOTS - 1);

  // Configuration registers
  logic [sesup_pkg::LimitsW-1:0] limits_q;
  logic [sesup_pkg::TimeW-1:0]   timeout_q;

  // Pipeline registers
  logic                  in_valid_q;
  sesup_pkg::in_beat_t   in_q;
  logic                  out_valid_q;
  sesup_pkg::out_beat_t  out_q, out_d;

  // Slot state
  logic [sesup_pkg::SlotW-1:0]  cur_slot_q, cur_slot_d;
  logic [sesup_pkg::CountW-1:0] err_q   [NUM_SLOTS];
  logic [sesup_pkg::CountW-1:0] err_d   [NUM_SLOTS];
  logic [sesup_pkg::TotalW-1:0] total_q [NUM_SLOTS];
  logic [sesup_pkg::TotalW-1:0] total_d [NUM_SLOTS];
  logic [sesup_pkg::TimeW-1:0]  stamp_q [NUM_SLOTS];
  logic [sesup_pkg::TimeW-1:0]  stamp_d [NUM_SLOTS];

  logic out_free, exec_fire;

  // Handshake: the result register frees when empty or taken
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec_fire  = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q  <= sesup_pkg::LimitsReset;
      timeout_q <= sesup_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sesup_pkg::REG_LIMITS:  limits_q  <= cfg_wdata_i;
        sesup_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata_i[sesup_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Capture input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.action       <= sesup_pkg::action_e'(action_i);
      in_q.test_status  <= sesup_pkg::status_e'(test_status_i);
      in_q.test_enabled <= test_enabled_i;
      in_q.now_ms       <= now_ms_i;
      in_q.read_index   <= read_index_i;
    end
  end

  // Slot access: one read address, shared by reports and reads
  logic                          is_read;
  logic [sesup_pkg::SlotW-1:0]   addr;
  logic [IdxW-1:0]               addr_idx;
  logic                          addr_ok;
  logic [sesup_pkg::CountW-1:0]  cnt_rd, lim;
  logic [sesup_pkg::TotalW-1:0]  total_rd;
  logic [sesup_pkg::TimeW-1:0]   stamp_rd, age;
  logic                          below, clear, fail_hit, upd;
  logic [sesup_pkg::CountW-1:0]  cnt_new;
  logic [sesup_pkg::TimeW-1:0]   stamp_new;
  logic [sesup_pkg::TotalW-1:0]  total_new;
  logic [sesup_pkg::SlotW-1:0]   nxt_slot;
  logic [NUM_SLOTS-1:0]          nonzero;

  assign is_read  = (in_q.action == sesup_pkg::ACT_READ);
  assign addr     = is_read ? in_q.read_index : cur_slot_q;
  assign addr_idx = addr[IdxW-1:0];
  assign addr_ok  = (addr <= LastSlot);
  assign cnt_rd   = err_q[addr_idx];
  assign total_rd = total_q[addr_idx];
  assign stamp_rd = stamp_q[addr_idx];

  // Limit nibble of the current slot; slots without a nibble read zero
  assign lim = (cur_slot_q < sesup_pkg::SlotW'(sesup_pkg::LimitSlots))
             ? limits_q[{cur_slot_q, 2'b00} +: sesup_pkg::CountW]
             : '0;

  // Timeout clear, then count a fail below the limit
  assign age       = in_q.now_ms - stamp_rd;
  assign below     = (cnt_rd < lim);
  assign clear     = below && (cnt_rd != '0) && (age >= timeout_q);
  assign fail_hit  = below && (in_q.test_status == sesup_pkg::ST_FAIL);
  assign cnt_new   = fail_hit ? ((clear ? '0 : cnt_rd) + 4'd1) : (clear ? '0 : cnt_rd);
  assign stamp_new = fail_hit ? in_q.now_ms : (clear ? '0 : stamp_rd);
  assign total_new = fail_hit ? (total_rd + 32'd1) : total_rd;
  assign upd       = exec_fire && !is_read;
  assign nxt_slot  = (cur_slot_q == LastSlot) ? '0 : cur_slot_q + 4'd1;

  // Write back slot state
  always_comb begin
    cur_slot_d = upd ? nxt_slot : cur_slot_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      err_d[i]   = err_q[i];
      total_d[i] = total_q[i];
      stamp_d[i] = stamp_q[i];
      if (upd && (IdxW'(i) == addr_idx)) begin
        err_d[i]   = cnt_new;
        total_d[i] = total_new;
        stamp_d[i] = stamp_new;
      end
    end
  end

  // All-pass sees the counts after this beat
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!is_read && (IdxW'(i) == addr_idx)) begin
        nonzero[i] = (cnt_new != '0);
      end else begin
        nonzero[i] = (err_q[i] != '0);
      end
    end
  end

  // Build result beat
  always_comb begin
    out_d = '0;
    out_d.slot      = addr;
    out_d.all_pass  = (nonzero == '0);
    if (is_read) begin
      out_d.error_count  = addr_ok ? cnt_rd : '0;
      out_d.total_errors = addr_ok ? total_rd : '0;
      out_d.next_slot    = cur_slot_q;
    end else begin
      out_d.run_enabled   = below && in_q.test_enabled;
      out_d.error_count   = cnt_new;
      out_d.total_errors  = total_new;
      out_d.count_cleared = clear;
      out_d.warning       = fail_hit && (cnt_new < lim);
      out_d.failed_now    = fail_hit && (cnt_new >= lim);
      out_d.heartbeat     = !below;
      out_d.next_slot     = nxt_slot;
    end
  end

  // Hold slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        err_q[i]   <= '0;
        total_q[i] <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      cur_slot_q <= cur_slot_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        err_q[i]   <= err_d[i];
        total_q[i] <= total_d[i];
        stamp_q[i] <= stamp_d[i];
      end
    end
  end

  // Advance result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  // Drive result ports
  assign out_valid_o     = out_valid_q;
  assign slot_o          = out_q.slot;
  assign run_enabled_o   = out_q.run_enabled;
  assign error_count_o   = out_q.error_count;
  assign total_errors_o  = out_q.total_errors;
  assign count_cleared_o = out_q.count_cleared;
  assign warning_o       = out_q.warning;
  assign failed_now_o    = out_q.failed_now;
  assign heartbeat_o     = out_q.heartbeat;
  assign next_slot_o     = out_q.next_slot;
  assign all_pass_o      = out_q.all_pass;

  // Slot pointer never leaves the slot range
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_slot_q <= LastSlot)
    else $error("slot pointer out of range");

  // A report moves the pointer by one slot, wrapping at the last
  a_slot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> (cur_slot_q == (($past(cur_slot_q) == LastSlot) ? '0 : $past(cur_slot_q) + 4'd1)))
    else $error("slot pointer did not advance");

  // A read leaves the pointer alone
  a_read_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && is_read) |=> $stable(cur_slot_q))
    else $error("read moved the slot pointer");

  // A blocked slot neither runs nor counts
  a_blocked_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.heartbeat) |->
      (!out_q.run_enabled && !out_q.warning && !out_q.failed_now && !out_q.count_cleared))
    else $error("blocked slot reported activity");

  // Warning and final failure exclude each other
  a_warn_fail_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.warning && out_q.failed_now))
    else $error("warning and failure both set");

endmodule
